// ----- src/kse_pkg.sv -----
`timescale 1ns / 1ps

package kse_pkg;

  // Key codes produced by the escapes.
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_LF    = 8'h0A;
  localparam logic [7:0] KEY_ESC   = 8'h1B;
  localparam logic [7:0] KEY_TAB   = 8'h09;
  localparam logic [7:0] KEY_SPACE = 8'h20;

  // Script characters with a special meaning.
  localparam logic [7:0] CH_END       = 8'h00;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_E   = 8'h65;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_S   = 8'h73;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;

  // Offsets that map a letter onto control codes 1 to 26.
  localparam logic [7:0] UPPER_CTRL_OFFSET = 8'h40;
  localparam logic [7:0] LOWER_CTRL_OFFSET = 8'h60;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESCAPE = 4'b0010,
    MODE_CARET  = 4'b0100,
    MODE_HEX    = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  hex_accum;
    logic [1:0]  hex_count;
  } dec_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] key;
    logic       is_wait;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] key;
    mode_t      mode;
  } plain_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t r;
    r.valid = 1'b1;
    r.value = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.value = c[3:0] + 4'd9;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == KEY_SPACE) || (c == KEY_TAB) || (c == KEY_CR) || (c == KEY_LF);
  endfunction

  // A byte outside any escape.
  function automatic plain_t plain_byte(input logic [7:0] c, input logic strip);
    plain_t r;
    r.valid = 1'b0;
    r.key   = c;
    r.mode  = MODE_NORMAL;
    if (c == CH_BACKSLASH) begin
      r.mode = MODE_ESCAPE;
    end else if (c != CH_END && !(strip && is_space(c))) begin
      r.valid = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- src/kse_decode.sv -----
`timescale 1ns / 1ps

module kse_decode import kse_pkg::*; (
  input  logic [7:0]  ch,
  input  logic        strip_whitespace,
  input  dec_state_t  cur,
  output dec_state_t  nxt,
  output res_t        res0,
  output res_t        res1
);

  plain_t      plain;
  hex_t        hex;
  res_t        flush;
  res_t        main;
  logic [7:0]  acc_shift;
  logic [1:0]  cnt_inc;

  assign plain     = plain_byte(ch, strip_whitespace);
  assign hex       = hex_digit(ch);
  assign acc_shift = {cur.hex_accum[3:0], hex.value};
  assign cnt_inc   = cur.hex_count + 2'd1;

  always_comb begin
    nxt           = cur;
    flush         = '0;
    main          = '0;
    main.key      = ch;
    unique case (cur.mode)
      MODE_NORMAL: begin
        nxt.mode   = plain.mode;
        main.valid = plain.valid;
      end
      MODE_ESCAPE: begin
        nxt.mode   = MODE_NORMAL;
        main.valid = 1'b1;
        case (ch)
          CH_END:     main.valid = 1'b0;
          CH_LOWER_R: main.key = KEY_CR;
          CH_LOWER_N: main.key = KEY_LF;
          CH_LOWER_E: main.key = KEY_ESC;
          CH_LOWER_T: main.key = KEY_TAB;
          CH_LOWER_S: main.key = KEY_SPACE;
          CH_DOT: begin
            main.key     = '0;
            main.is_wait = 1'b1;
          end
          CH_CARET: begin
            nxt.mode   = MODE_CARET;
            main.valid = 1'b0;
          end
          CH_LOWER_X: begin
            nxt.mode      = MODE_HEX;
            nxt.hex_accum = '0;
            nxt.hex_count = '0;
            main.valid    = 1'b0;
          end
          default: main.key = ch;
        endcase
      end
      MODE_CARET: begin
        if (ch >= 8'h41 && ch <= 8'h5A) begin
          nxt.mode   = MODE_NORMAL;
          main.valid = 1'b1;
          main.key   = ch - UPPER_CTRL_OFFSET;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
          nxt.mode   = MODE_NORMAL;
          main.valid = 1'b1;
          main.key   = ch - LOWER_CTRL_OFFSET;
        end else begin
          nxt.mode   = plain.mode;
          main.valid = plain.valid;
        end
      end
      MODE_HEX: begin
        if (hex.valid) begin
          if (cnt_inc >= 2'd2) begin
            // Second digit completes the byte; a zero byte is dropped.
            nxt.mode      = MODE_NORMAL;
            nxt.hex_accum = '0;
            nxt.hex_count = '0;
            main.valid    = (acc_shift != 8'h00);
            main.key      = acc_shift;
          end else begin
            nxt.hex_accum = acc_shift;
            nxt.hex_count = cnt_inc;
          end
        end else begin
          // A non-hex byte flushes what was gathered, then stands on its own.
          flush.valid   = (cur.hex_count != 2'd0) && (cur.hex_accum != 8'h00);
          flush.key     = cur.hex_accum;
          nxt.hex_accum = '0;
          nxt.hex_count = '0;
          nxt.mode      = plain.mode;
          main.valid    = plain.valid;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // Pack the results so that the first slot is always filled first.
  always_comb begin
    if (flush.valid) begin
      res0      = flush;
      res0.last = !main.valid;
      res1      = main;
      res1.last = main.valid;
    end else begin
      res0      = main;
      res0.last = main.valid;
      res1      = '0;
    end
  end

endmodule

// ----- src/kse_fifo.sv -----
`timescale 1ns / 1ps

module kse_fifo import kse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  res_t        push0,
  input  res_t        push1,
  input  logic        pop,
  output res_t        head,
  output logic        not_empty,
  output logic        room
);

  res_t                mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [FIFO_CW-1:0]  count;
  logic [FIFO_CW-1:0]  count_next;
  logic [FIFO_AW-1:0]  wr_ptr_next;
  logic                do_pop;

  assign do_pop      = pop && (count != '0);
  assign wr_ptr_next = wr_ptr + FIFO_AW'(push0.valid) + FIFO_AW'(push1.valid);
  assign count_next  = count + FIFO_CW'(push0.valid) + FIFO_CW'(push1.valid)
                       - FIFO_CW'(do_pop);

  always_ff @(posedge clk) begin
    if (push0.valid) begin
      mem[wr_ptr] <= push0;
    end
    if (push1.valid) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
    end
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  // Room for the largest burst one byte can cause.
  assign room      = (count <= FIFO_CW'(FIFO_DEPTH - 2));

endmodule

// ----- src/key_script_escape_decoder.sv -----
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_stall     ch[7:0]
// output    out_valid / out_stall   key[7:0], is_wait, last_of_run
// config    cfg_wr_en               cfg_wr_data (strip_whitespace)
//
// One byte is accepted per cycle while in_stall is low. A byte is held in the input register,
// is decoded on its way into a four-entry result queue, and its first result
// is offered at the queue head once it has been written into the queue.
// The queue sets the rate: input stalls while it holds more than two entries,
// so a byte with two results, or output stalls, back up the input briefly.
// Reset (rst, synchronous) empties the queue, returns to normal mode and
// clears strip_whitespace.
module key_script_escape_decoder import kse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] key,
  output logic       is_wait,
  output logic       last_of_run
);

  logic        strip_whitespace;
  logic        st_valid;
  logic [7:0]  st_ch;
  dec_state_t  dstate;
  dec_state_t  dstate_next;
  res_t        res0;
  res_t        res1;
  res_t        push0;
  res_t        push1;
  res_t        head;
  logic        room;
  logic        stage_move;
  logic        in_accept;

  // The held byte leaves the input register once the queue can take
  // both of its possible results. Everything here is registered, so no
  // path runs from out_stall to in_stall.
  assign stage_move = st_valid && room;
  assign in_stall   = st_valid && !room;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_whitespace <= 1'b0;
    end else if (cfg_wr_en) begin
      strip_whitespace <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_accept) begin
      st_valid <= 1'b1;
    end else if (stage_move) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      st_ch <= ch;
    end
  end

  // Decoder state advances only when the held byte is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate.mode      <= MODE_NORMAL;
      dstate.hex_accum <= '0;
      dstate.hex_count <= '0;
    end else if (stage_move) begin
      dstate <= dstate_next;
    end
  end

  kse_decode u_decode (
    .ch               (st_ch),
    .strip_whitespace (strip_whitespace),
    .cur              (dstate),
    .nxt              (dstate_next),
    .res0             (res0),
    .res1             (res1)
  );

  always_comb begin
    push0       = res0;
    push1       = res1;
    push0.valid = res0.valid && stage_move;
    push1.valid = res1.valid && stage_move;
  end

  kse_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .pop       (!out_stall),
    .head      (head),
    .not_empty (out_valid),
    .room      (room)
  );

  assign key         = head.key;
  assign is_wait     = head.is_wait;
  assign last_of_run = head.last;

`ifndef SYNTHESIS
  // A stall is only raised while a byte waits in the input register.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> st_valid)
    else $error("input stalled with empty input register");

  // Outside a hex escape no digits are pending.
  assert property (@(posedge clk) disable iff (rst)
      dstate.mode != MODE_HEX |-> (dstate.hex_count == 2'd0 && dstate.hex_accum == 8'h00))
    else $error("hex digits pending outside hex mode");

  // A hex escape never holds two digits: the second completes the byte.
  assert property (@(posedge clk) disable iff (rst)
      dstate.mode == MODE_HEX |-> dstate.hex_count <= 2'd1)
    else $error("hex escape held more than one digit");

  // A second result only comes with a first, and only the second is last.
  assert property (@(posedge clk) disable iff (rst)
      res1.valid |-> (res0.valid && !res0.last && res1.last))
    else $error("malformed result pair");
`endif

endmodule
